@@ sv/lwnc_pkg.sv @@
// Package: shared constants, commands, payload and cell interface types.
`default_nettype none
package lwnc_pkg;

    localparam int CAPACITY = 16;
    localparam int POS_W    = 32;
    localparam int DATA_W   = 64;
    localparam int RANK_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int STAT_W   = 32;
    localparam int LEVEL_W  = 5;

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(16);
    localparam logic [STAT_W-1:0]  STAT_MAX    = '1;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_FILL   = 3'd1,
        CMD_WRITE  = 3'd2,
        CMD_FLUSH  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WT,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [2:0]        command;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] data;
    } t_in_item;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] read_data;
        logic              mem_write;
        logic [POS_W-1:0]  mem_position;
        logic [DATA_W-1:0] mem_data;
        logic              last;
        logic [STAT_W-1:0] hits_so_far;
        logic [STAT_W-1:0] misses_so_far;
        logic [CNT_W-1:0]  occupancy;
    } t_out_item;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              update;
        logic              put;
        logic              dirty;
        logic              hit;
        logic              full;
        logic              shift;
        logic [RANK_W-1:0] ref_rank;
        logic [RANK_W-1:0] new_rank;
        logic              clear;
        logic              tok_shift;
        logic              tok_clear;
    } t_cell_ctl;

    // Status each cell reports back to the sequencer
    typedef struct packed {
        logic              match;
        logic              victim;
        logic              vdirty;
        logic              tok;
        logic              rest;
        logic [RANK_W-1:0] rank;
        logic [POS_W-1:0]  tag;
        logic [DATA_W-1:0] data;
    } t_cell_stat;

endpackage
`default_nettype wire

@@ sv/lwnc_cell.sv @@
// One cache entry: tag, data, valid, dirty, recency rank and flush token.
`default_nettype none
module lwnc_cell (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire lwnc_pkg::t_cell_ctl     i_ctl,
    input  wire [lwnc_pkg::POS_W-1:0]    i_pos,
    input  wire [lwnc_pkg::DATA_W-1:0]   i_data,
    input  wire                          i_free_seen,
    output logic                         o_free_seen,
    input  wire                          i_tok,
    output logic                         o_tok,
    input  wire                          i_dirty_after,
    output logic                         o_dirty_after,
    output lwnc_pkg::t_cell_stat         o_stat
);

    logic                          r_valid;
    logic                          r_dirty;
    logic [lwnc_pkg::RANK_W-1:0]   r_rank;
    logic                          r_tok;
    logic [lwnc_pkg::POS_W-1:0]    r_tag;
    logic [lwnc_pkg::DATA_W-1:0]   r_data;

    logic match;
    logic victim;
    logic free_here;
    logic target;
    logic vdirty;

    // Local compares and priority chains
    always_comb begin
        match         = r_valid && (r_tag == i_pos);
        victim        = r_valid && (r_rank == '0);
        free_here     = !r_valid && !i_free_seen;
        o_free_seen   = i_free_seen || !r_valid;
        vdirty        = r_valid && r_dirty;
        o_dirty_after = vdirty || i_dirty_after;
        o_tok         = r_tok;
        if (i_ctl.put) begin
            target = i_ctl.hit ? match : (i_ctl.full ? victim : free_here);
        end else begin
            target = match;
        end
        o_stat.match  = match;
        o_stat.victim = victim;
        o_stat.vdirty = vdirty;
        o_stat.tok    = r_tok;
        o_stat.rest   = r_tok && i_dirty_after;
        o_stat.rank   = r_rank;
        o_stat.tag    = r_tag;
        o_stat.data   = r_data;
    end

    // Control state: valid, dirty, rank, token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= '0;
            r_tok   <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
            r_rank  <= '0;
        end else begin
            if (i_ctl.update && target) begin
                r_rank <= i_ctl.new_rank;
                if (i_ctl.put) begin
                    r_valid <= 1'b1;
                    r_dirty <= i_ctl.dirty;
                end
            end else if (i_ctl.update && i_ctl.shift && r_valid
                         && (r_rank > i_ctl.ref_rank)) begin
                r_rank <= r_rank - 1'b1;
            end
            // Clean the entry under the token as it is written back
            if (r_tok && (i_ctl.tok_shift || i_ctl.tok_clear)) begin
                r_dirty <= 1'b0;
            end
            if (i_ctl.tok_clear) begin
                r_tok <= 1'b0;
            end else if (i_ctl.tok_shift) begin
                r_tok <= i_tok;
            end
        end
    end

    // Payload: tag and data
    always_ff @(posedge i_clk) begin
        if (i_ctl.update && i_ctl.put && target) begin
            r_tag  <= i_pos;
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

@@ sv/lru_writeback_node_cache.sv @@
// Fully associative LRU write-back cache: a row of entry cells and the command sequencer.
//
// Input channel (i_in_valid, i_in, o_in_stall) carries one command with its
// position and data. A command is taken when valid is high and stall is low;
// stall stays high from the transfer until the command's last result has been
// handed to the output register.
// Output channel (o_out_valid, o_out, i_out_stall) carries the results; the
// final result of each command has last set. Results sit in one output
// register and hold while i_out_stall is high; the sequencer waits for a free
// output slot before it retires a step.
// Lookup, fill, write, clear and unknown commands are a transfer, then one step
// across all cells (tag compare, and rank update on a lookup hit or a put). A put
// that evicts a dirty entry and also writes through gives the eviction result,
// then the write-through result. A flush passes a token down the row of cells,
// one entry per cycle unless a dirty entry waits on a stalled output.
// Configuration (i_cfg_valid, i_cfg_data, o_cfg_ready) writes the write-through
// level; ready is always high and writes belong in idle periods.
// Reset (i_rst_n low, synchronous) empties the cache, zeroes the counters,
// sets the level to 16 and drops any pending result.
`default_nettype none
module lru_writeback_node_cache (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    input  wire lwnc_pkg::t_in_item          i_in,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output lwnc_pkg::t_out_item              o_out,
    input  wire                              i_out_stall,
    input  wire                              i_cfg_valid,
    input  wire [lwnc_pkg::LEVEL_W-1:0]      i_cfg_data,
    output logic                             o_cfg_ready
);

    localparam int CAP = lwnc_pkg::CAPACITY;

    lwnc_pkg::t_state                 r_state, n_state;
    lwnc_pkg::t_in_item               r_cmd;
    logic [lwnc_pkg::LEVEL_W-1:0]     r_level;
    logic [lwnc_pkg::STAT_W-1:0]      r_hits, n_hits;
    logic [lwnc_pkg::STAT_W-1:0]      r_misses, n_misses;
    logic [lwnc_pkg::CNT_W-1:0]       r_count, n_count;
    logic                             r_out_valid;
    lwnc_pkg::t_out_item              r_out, n_out;

    lwnc_pkg::t_cell_ctl              ctl;
    lwnc_pkg::t_cell_stat             stat [CAP];
    logic [CAP:0]                     free_chain;
    logic [CAP:0]                     tok_chain;
    logic [CAP:0]                     dirty_chain;

    logic                             emit;
    logic                             out_free;
    logic                             tok_start;

    // Reduced cell status
    logic                             hit;
    logic [lwnc_pkg::RANK_W-1:0]      sel_rank;
    logic [lwnc_pkg::DATA_W-1:0]      sel_data;
    logic [lwnc_pkg::POS_W-1:0]       vic_tag;
    logic [lwnc_pkg::DATA_W-1:0]      vic_data;
    logic                             vic_dirty;
    logic [lwnc_pkg::POS_W-1:0]       tok_tag;
    logic [lwnc_pkg::DATA_W-1:0]      tok_data;
    logic                             tok_dirty;
    logic                             tok_rest;

    // Command decode helpers
    logic                             is_write;
    logic                             full;
    logic                             wt;
    logic                             evict;

    // Row of entry cells
    assign free_chain[0]     = 1'b0;
    assign tok_chain[0]      = tok_start;
    assign dirty_chain[CAP]  = 1'b0;

    for (genvar g = 0; g < CAP; g++) begin : g_cell
        lwnc_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_pos         (r_cmd.position),
            .i_data        (r_cmd.data),
            .i_free_seen   (free_chain[g]),
            .o_free_seen   (free_chain[g+1]),
            .i_tok         (tok_chain[g]),
            .o_tok         (tok_chain[g+1]),
            .i_dirty_after (dirty_chain[g+1]),
            .o_dirty_after (dirty_chain[g]),
            .o_stat        (stat[g])
        );
    end

    // Collect the one-hot selections from the cells
    always_comb begin
        hit       = 1'b0;
        sel_rank  = '0;
        sel_data  = '0;
        vic_tag   = '0;
        vic_data  = '0;
        vic_dirty = 1'b0;
        tok_tag   = '0;
        tok_data  = '0;
        tok_dirty = 1'b0;
        tok_rest  = 1'b0;
        for (int i = 0; i < CAP; i++) begin
            if (stat[i].match) begin
                hit      = 1'b1;
                sel_rank = sel_rank | stat[i].rank;
                sel_data = sel_data | stat[i].data;
            end
            if (stat[i].victim) begin
                vic_tag   = vic_tag | stat[i].tag;
                vic_data  = vic_data | stat[i].data;
                vic_dirty = vic_dirty | stat[i].vdirty;
            end
            if (stat[i].tok) begin
                tok_tag   = tok_tag | stat[i].tag;
                tok_data  = tok_data | stat[i].data;
                tok_dirty = tok_dirty | stat[i].vdirty;
                tok_rest  = tok_rest | stat[i].rest;
            end
        end
    end

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != lwnc_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign is_write = (r_cmd.command == lwnc_pkg::CMD_WRITE);
    assign full     = (r_count == lwnc_pkg::CNT_W'(CAP));
    assign evict    = !hit && full && vic_dirty;

    // Sequencer: next state, cell control and result
    always_comb begin
        n_state   = r_state;
        n_hits    = r_hits;
        n_misses  = r_misses;
        n_count   = r_count;
        ctl       = '0;
        tok_start = 1'b0;
        emit      = 1'b0;
        wt        = 1'b0;
        n_out     = '0;

        unique case (r_state)
            lwnc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = lwnc_pkg::ST_EXEC;
                end
            end

            lwnc_pkg::ST_EXEC: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_out.last = 1'b1;
                    n_state    = lwnc_pkg::ST_IDLE;
                    case (r_cmd.command)
                        lwnc_pkg::CMD_LOOKUP: begin
                            if (hit) begin
                                ctl.update      = 1'b1;
                                ctl.shift       = 1'b1;
                                ctl.ref_rank    = sel_rank;
                                ctl.new_rank    = lwnc_pkg::RANK_W'(r_count - 1'b1);
                                n_hits          = (r_hits == lwnc_pkg::STAT_MAX) ?
                                                  r_hits : r_hits + 1'b1;
                                n_out.hit       = 1'b1;
                                n_out.read_data = sel_data;
                            end else begin
                                n_misses = (r_misses == lwnc_pkg::STAT_MAX) ?
                                           r_misses : r_misses + 1'b1;
                            end
                        end
                        lwnc_pkg::CMD_FILL, lwnc_pkg::CMD_WRITE: begin
                            ctl.update   = 1'b1;
                            ctl.put      = 1'b1;
                            ctl.dirty    = is_write;
                            ctl.hit      = hit;
                            ctl.full     = full;
                            ctl.shift    = hit || full;
                            ctl.ref_rank = hit ? sel_rank : '0;
                            if (hit || full) begin
                                ctl.new_rank = lwnc_pkg::RANK_W'(r_count - 1'b1);
                            end else begin
                                ctl.new_rank = lwnc_pkg::RANK_W'(r_count);
                                n_count      = r_count + 1'b1;
                            end
                            wt = is_write && (32'(n_count) >= 32'(r_level));
                            if (evict) begin
                                n_out.mem_write    = 1'b1;
                                n_out.mem_position = vic_tag;
                                n_out.mem_data     = vic_data;
                                if (wt) begin
                                    n_out.last = 1'b0;
                                    n_state    = lwnc_pkg::ST_WT;
                                end
                            end else if (wt) begin
                                n_out.mem_write    = 1'b1;
                                n_out.mem_position = r_cmd.position;
                                n_out.mem_data     = r_cmd.data;
                            end
                        end
                        lwnc_pkg::CMD_FLUSH: begin
                            if (dirty_chain[0]) begin
                                // Start the token at the first cell
                                emit          = 1'b0;
                                tok_start     = 1'b1;
                                ctl.tok_shift = 1'b1;
                                n_state       = lwnc_pkg::ST_FLUSH;
                            end
                        end
                        lwnc_pkg::CMD_CLEAR: begin
                            ctl.clear = 1'b1;
                            n_hits    = '0;
                            n_misses  = '0;
                            n_count   = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            lwnc_pkg::ST_WT: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.mem_write    = 1'b1;
                    n_out.mem_position = r_cmd.position;
                    n_out.mem_data     = r_cmd.data;
                    n_out.last         = 1'b1;
                    n_state            = lwnc_pkg::ST_IDLE;
                end
            end

            lwnc_pkg::ST_FLUSH: begin
                if (!tok_dirty) begin
                    ctl.tok_shift = 1'b1;
                end else if (out_free) begin
                    emit               = 1'b1;
                    n_out.mem_write    = 1'b1;
                    n_out.mem_position = tok_tag;
                    n_out.mem_data     = tok_data;
                    n_out.last         = !tok_rest;
                    if (tok_rest) begin
                        ctl.tok_shift = 1'b1;
                    end else begin
                        ctl.tok_clear = 1'b1;
                        n_state       = lwnc_pkg::ST_IDLE;
                    end
                end
            end

            default: begin
                n_state = lwnc_pkg::ST_IDLE;
            end
        endcase

        n_out.hits_so_far   = n_hits;
        n_out.misses_so_far = n_misses;
        n_out.occupancy     = n_count;
    end

    // State, counters, level and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lwnc_pkg::ST_IDLE;
            r_hits      <= '0;
            r_misses    <= '0;
            r_count     <= '0;
            r_level     <= lwnc_pkg::LEVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_hits   <= n_hits;
            r_misses <= n_misses;
            r_count  <= n_count;
            if (i_cfg_valid) begin
                r_level <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the command on transfer; load a result into the output register
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_cmd <= i_in;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
